// ===== rtl/radial_force_linear_falloff_unit_assert.svh =====
// assertion macros used by the checker file
`ifndef RADIAL_FORCE_LINEAR_FALLOFF_UNIT_ASSERT_SVH
`define RADIAL_FORCE_LINEAR_FALLOFF_UNIT_ASSERT_SVH

// property checked while reset is released
`define RFLF_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
        else $error("rflf assertion failed");

// property checked on every edge, reset included
`define RFLF_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) (prop)) \
        else $error("rflf assertion failed");

`endif

// ===== rtl/rflf_pkg.sv =====
// shared types and constants of the radial force unit
`timescale 1ns / 1ps

package rflf_pkg;

    localparam int POS_W   = 24;              // signed Q15.8 position
    localparam int ABS_W   = 24;              // magnitude of a position difference
    localparam int RAD_W   = 23;              // unsigned Q15.8 radius
    localparam int STR_W   = 24;              // signed Q7.16 strength
    localparam int FORCE_W = 24;              // signed Q7.16 force
    localparam int FRAC_W  = 16;              // fraction bits of unit vector and falloff
    localparam int QUO_W   = FRAC_W + 1;      // quotients reach 1.0 exactly
    localparam int SQ_W    = 2 * ABS_W;       // one squared component
    localparam int RR_W    = 2 * RAD_W;       // squared radius
    localparam int SUM_W   = 2 * ABS_W + 2;   // squared length, even width for sqrt
    localparam int ROOT_W  = SUM_W / 2;       // length
    localparam int PCT_N_W = RAD_W + FRAC_W;  // falloff dividend
    localparam int U_N_W   = ABS_W + FRAC_W;  // unit vector dividend
    localparam int P1_W    = STR_W + QUO_W;   // strength times unit
    localparam int P2_W    = P1_W + QUO_W;    // times falloff

    typedef struct packed {
        logic signed [POS_W-1:0] particle_x;
        logic signed [POS_W-1:0] particle_y;
        logic signed [POS_W-1:0] source_x;
        logic signed [POS_W-1:0] source_y;
        logic [RAD_W-1:0]        radius;
        logic signed [STR_W-1:0] strength;
        logic                    direction;
    } in_t;

    typedef struct packed {
        logic signed [FORCE_W-1:0] force_x;
        logic signed [FORCE_W-1:0] force_y;
        logic                      in_range;
    } out_t;

    // per-word side data that travels beside the arithmetic
    typedef struct packed {
        logic [ABS_W-1:0] adx;
        logic [ABS_W-1:0] ady;
        logic             xneg;
        logic             yneg;
        logic [STR_W-1:0] smag;
        logic             sneg;
        logic [RAD_W-1:0] radius;
        logic             attract;
        logic             inr;
        logic             zero;
        logic             vld;
    } ctl_t;

endpackage

// ===== rtl/rflf_delay.sv =====
// enable-gated delay line for side data
`timescale 1ns / 1ps

module rflf_delay #(
    parameter int W     = 8,
    parameter int DEPTH = 4
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         en,
    input  logic [W-1:0] d,
    output logic [W-1:0] q
);

    logic [W-1:0] pipe_reg [DEPTH];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < DEPTH; k++) begin
                pipe_reg[k] <= '0;
            end
        end else if (en) begin
            pipe_reg[0] <= d;
            for (int k = 1; k < DEPTH; k++) begin
                pipe_reg[k] <= pipe_reg[k-1];
            end
        end
    end

    assign q = pipe_reg[DEPTH-1];

endmodule

// ===== rtl/rflf_isqrt.sv =====
// pipelined integer square root, one root bit per stage
`timescale 1ns / 1ps

module rflf_isqrt #(
    parameter int SUM_W  = rflf_pkg::SUM_W,
    parameter int ROOT_W = rflf_pkg::ROOT_W
) (
    input  logic              aclk,
    input  logic              en,
    input  logic [SUM_W-1:0]  s,
    output logic [ROOT_W-1:0] root
);

    localparam int REM_W = ROOT_W + 2;

    logic [REM_W-1:0]  rem_reg  [ROOT_W];
    logic [ROOT_W-1:0] root_reg [ROOT_W];
    logic [SUM_W-1:0]  bits_reg [ROOT_W];

    logic [REM_W-1:0]  rem_prev  [ROOT_W];
    logic [ROOT_W-1:0] root_prev [ROOT_W];
    logic [SUM_W-1:0]  bits_prev [ROOT_W];
    logic [REM_W-1:0]  rem_in    [ROOT_W];
    logic [REM_W-1:0]  trial     [ROOT_W];
    logic              ge        [ROOT_W];

    for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
        if (k == 0) begin : g_first
            assign rem_prev[k]  = '0;
            assign root_prev[k] = '0;
            assign bits_prev[k] = s;
        end else begin : g_next
            assign rem_prev[k]  = rem_reg[k-1];
            assign root_prev[k] = root_reg[k-1];
            assign bits_prev[k] = bits_reg[k-1];
        end
        assign rem_in[k] = {rem_prev[k][REM_W-3:0], bits_prev[k][SUM_W-1 -: 2]};
        assign trial[k]  = {root_prev[k], 2'b01};
        assign ge[k]     = (rem_in[k] >= trial[k]);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int k = 0; k < ROOT_W; k++) begin
                rem_reg[k]  <= ge[k] ? rem_in[k] - trial[k] : rem_in[k];
                root_reg[k] <= {root_prev[k][ROOT_W-2:0], ge[k]};
                bits_reg[k] <= bits_prev[k] << 2;
            end
        end
    end

    assign root = root_reg[ROOT_W-1];

endmodule

// ===== rtl/rflf_div.sv =====
// pipelined restoring divider, one quotient bit per stage
`timescale 1ns / 1ps

module rflf_div #(
    parameter int NUM_W = rflf_pkg::U_N_W,
    parameter int DEN_W = rflf_pkg::ROOT_W,
    parameter int QUO_W = rflf_pkg::QUO_W
) (
    input  logic             aclk,
    input  logic             en,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic [QUO_W-1:0] quo
);

    // quotient is known to fit QUO_W bits, so the top of num is below den
    logic [DEN_W-1:0] rem_reg [QUO_W];
    logic [QUO_W-1:0] quo_reg [QUO_W];
    logic [QUO_W-1:0] lo_reg  [QUO_W];
    logic [DEN_W-1:0] den_reg [QUO_W];

    logic [DEN_W-1:0] rem_prev [QUO_W];
    logic [QUO_W-1:0] quo_prev [QUO_W];
    logic [QUO_W-1:0] lo_prev  [QUO_W];
    logic [DEN_W-1:0] den_prev [QUO_W];
    logic [DEN_W:0]   rem_in   [QUO_W];
    logic             ge       [QUO_W];

    for (genvar k = 0; k < QUO_W; k++) begin : g_stage
        if (k == 0) begin : g_first
            assign rem_prev[k] = DEN_W'(num[NUM_W-1:QUO_W]);
            assign quo_prev[k] = '0;
            assign lo_prev[k]  = num[QUO_W-1:0];
            assign den_prev[k] = den;
        end else begin : g_next
            assign rem_prev[k] = rem_reg[k-1];
            assign quo_prev[k] = quo_reg[k-1];
            assign lo_prev[k]  = lo_reg[k-1];
            assign den_prev[k] = den_reg[k-1];
        end
        assign rem_in[k] = {rem_prev[k], lo_prev[k][QUO_W-1]};
        assign ge[k]     = (rem_in[k] >= {1'b0, den_prev[k]});
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int k = 0; k < QUO_W; k++) begin
                rem_reg[k] <= ge[k] ? DEN_W'(rem_in[k] - {1'b0, den_prev[k]})
                                    : rem_in[k][DEN_W-1:0];
                quo_reg[k] <= {quo_prev[k][QUO_W-2:0], ge[k]};
                lo_reg[k]  <= lo_prev[k] << 1;
                den_reg[k] <= den_prev[k];
            end
        end
    end

    assign quo = quo_reg[QUO_W-1];

endmodule

// ===== rtl/radial_force_linear_falloff_unit.sv =====
// top level of the radial force unit with linear falloff
`timescale 1ns / 1ps

// Radial attraction/repulsion force with linear falloff. Each input word
// carries a particle position, a source position (Q15.8), a radius (Q15.8,
// zero means unlimited range at full strength), a strength (Q7.16) and an
// attract flag; each result word carries the force increment
// strength*(1-length/radius) along the unit offset, rounded half away from
// zero and saturated to 24 bits, plus an in-range flag. Beyond the radius or
// at zero distance the force is zero. The unit takes one word per cycle and
// returns one per cycle while m_ready is high; a word passes three setup
// stages, a 25-stage square root (one root bit per stage), one stage, three
// 17-stage dividers side by side (one quotient bit per stage), two multiply
// stages, one round/saturate stage and the output register. A skid register
// at the output lets s_ready follow a registered flag only.

module radial_force_linear_falloff_unit (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  rflf_pkg::in_t  s_data,
    output logic           m_valid,
    input  logic           m_ready,
    output rflf_pkg::out_t m_data
);

    localparam int CTL_W = $bits(rflf_pkg::ctl_t);

    // saturate a rounded magnitude with its sign into a force word
    function automatic logic [rflf_pkg::FORCE_W-1:0] sat_force(
        input logic [rflf_pkg::P2_W-rflf_pkg::FRAC_W*2:0] mag,
        input logic neg
    );
        logic [rflf_pkg::FORCE_W-1:0] res;
        if (neg) begin
            if (mag >= (1 << (rflf_pkg::FORCE_W - 1))) begin
                res = {1'b1, {(rflf_pkg::FORCE_W-1){1'b0}}};
            end else begin
                res = -mag[rflf_pkg::FORCE_W-1:0];
            end
        end else begin
            if (mag >= (1 << (rflf_pkg::FORCE_W - 1))) begin
                res = {1'b0, {(rflf_pkg::FORCE_W-1){1'b1}}};
            end else begin
                res = mag[rflf_pkg::FORCE_W-1:0];
            end
        end
        return res;
    endfunction

    // whole pipeline moves while the skid register is empty
    logic en;
    logic skid_vld_reg;
    assign en      = !skid_vld_reg;
    assign s_ready = en;

    // stage 1: offsets and magnitudes
    logic signed [rflf_pkg::POS_W:0] dx, dy;
    logic signed [rflf_pkg::STR_W-1:0] st;
    rflf_pkg::ctl_t c1_reg;

    assign dx = {s_data.particle_x[rflf_pkg::POS_W-1], s_data.particle_x}
              - {s_data.source_x[rflf_pkg::POS_W-1], s_data.source_x};
    assign dy = {s_data.particle_y[rflf_pkg::POS_W-1], s_data.particle_y}
              - {s_data.source_y[rflf_pkg::POS_W-1], s_data.source_y};
    assign st = s_data.strength;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            c1_reg.vld <= 1'b0;
        end else if (en) begin
            c1_reg.vld     <= s_valid;
            c1_reg.adx     <= dx[rflf_pkg::POS_W] ? rflf_pkg::ABS_W'(-dx)
                                                  : rflf_pkg::ABS_W'(dx);
            c1_reg.ady     <= dy[rflf_pkg::POS_W] ? rflf_pkg::ABS_W'(-dy)
                                                  : rflf_pkg::ABS_W'(dy);
            c1_reg.xneg    <= dx[rflf_pkg::POS_W];
            c1_reg.yneg    <= dy[rflf_pkg::POS_W];
            c1_reg.smag    <= st[rflf_pkg::STR_W-1] ? -st : st;
            c1_reg.sneg    <= st[rflf_pkg::STR_W-1];
            c1_reg.radius  <= s_data.radius;
            c1_reg.attract <= s_data.direction;
            c1_reg.inr     <= 1'b0;
            c1_reg.zero    <= 1'b0;
        end
    end

    // stage 2: squares of the offsets and of the radius
    logic [rflf_pkg::SQ_W-1:0] sqx_reg, sqy_reg;
    logic [rflf_pkg::RR_W-1:0] rr_reg;
    rflf_pkg::ctl_t c2_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            c2_reg.vld <= 1'b0;
        end else if (en) begin
            c2_reg  <= c1_reg;
            sqx_reg <= c1_reg.adx * c1_reg.adx;
            sqy_reg <= c1_reg.ady * c1_reg.ady;
            rr_reg  <= c1_reg.radius * c1_reg.radius;
        end
    end

    // stage 3: squared length, range test, zero distance
    logic [rflf_pkg::SUM_W-1:0] sum;
    logic [rflf_pkg::SUM_W-1:0] s3_reg;
    rflf_pkg::ctl_t c3_reg;
    rflf_pkg::ctl_t c3_next;

    assign sum = rflf_pkg::SUM_W'(sqx_reg) + rflf_pkg::SUM_W'(sqy_reg);

    always_comb begin
        c3_next      = c2_reg;
        c3_next.inr  = (c2_reg.radius == '0) || (sum <= rflf_pkg::SUM_W'(rr_reg));
        c3_next.zero = (sum == '0);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            c3_reg.vld <= 1'b0;
        end else if (en) begin
            c3_reg <= c3_next;
            s3_reg <= sum;
        end
    end

    // square root with side data alongside
    logic [rflf_pkg::ROOT_W-1:0] root;
    logic [CTL_W-1:0] c3d;
    rflf_pkg::ctl_t c4d;

    rflf_isqrt #(
        .SUM_W  (rflf_pkg::SUM_W),
        .ROOT_W (rflf_pkg::ROOT_W)
    ) u_isqrt (
        .aclk (aclk),
        .en   (en),
        .s    (s3_reg),
        .root (root)
    );

    rflf_delay #(
        .W     (CTL_W),
        .DEPTH (rflf_pkg::ROOT_W)
    ) u_sqrt_dly (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (en),
        .d       (c3_reg),
        .q       (c3d)
    );
    assign c4d = rflf_pkg::ctl_t'(c3d);

    // stage 4: radius minus length, floored at zero
    logic [rflf_pkg::ROOT_W-1:0] l4_reg;
    logic [rflf_pkg::RAD_W-1:0]  rdiff4_reg;
    logic [rflf_pkg::ROOT_W-1:0] rad_ext;
    rflf_pkg::ctl_t c4_reg;

    assign rad_ext = rflf_pkg::ROOT_W'(c4d.radius);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            c4_reg.vld <= 1'b0;
        end else if (en) begin
            c4_reg     <= c4d;
            l4_reg     <= root;
            rdiff4_reg <= (rad_ext >= root) ? rflf_pkg::RAD_W'(rad_ext - root) : '0;
        end
    end

    // falloff and unit vector dividers
    logic [rflf_pkg::QUO_W-1:0] pct_q, ux_q, uy_q;
    logic [CTL_W-1:0] c4dd;
    rflf_pkg::ctl_t c5d;

    rflf_div #(
        .NUM_W (rflf_pkg::PCT_N_W),
        .DEN_W (rflf_pkg::RAD_W),
        .QUO_W (rflf_pkg::QUO_W)
    ) u_div_pct (
        .aclk (aclk),
        .en   (en),
        .num  ({rdiff4_reg, {rflf_pkg::FRAC_W{1'b0}}}),
        .den  (c4_reg.radius),
        .quo  (pct_q)
    );

    rflf_div #(
        .NUM_W (rflf_pkg::U_N_W),
        .DEN_W (rflf_pkg::ROOT_W),
        .QUO_W (rflf_pkg::QUO_W)
    ) u_div_ux (
        .aclk (aclk),
        .en   (en),
        .num  ({c4_reg.adx, {rflf_pkg::FRAC_W{1'b0}}}),
        .den  (l4_reg),
        .quo  (ux_q)
    );

    rflf_div #(
        .NUM_W (rflf_pkg::U_N_W),
        .DEN_W (rflf_pkg::ROOT_W),
        .QUO_W (rflf_pkg::QUO_W)
    ) u_div_uy (
        .aclk (aclk),
        .en   (en),
        .num  ({c4_reg.ady, {rflf_pkg::FRAC_W{1'b0}}}),
        .den  (l4_reg),
        .quo  (uy_q)
    );

    rflf_delay #(
        .W     (CTL_W),
        .DEPTH (rflf_pkg::QUO_W)
    ) u_div_dly (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (en),
        .d       (c4_reg),
        .q       (c4dd)
    );
    assign c5d = rflf_pkg::ctl_t'(c4dd);

    // stage 5: strength times unit, full falloff for unlimited range
    logic [rflf_pkg::P1_W-1:0]  px5_reg, py5_reg;
    logic [rflf_pkg::QUO_W-1:0] pct5_reg;
    rflf_pkg::ctl_t c5_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            c5_reg.vld <= 1'b0;
        end else if (en) begin
            c5_reg   <= c5d;
            px5_reg  <= c5d.smag * ux_q;
            py5_reg  <= c5d.smag * uy_q;
            pct5_reg <= (c5d.radius == '0) ? rflf_pkg::QUO_W'(1 << rflf_pkg::FRAC_W)
                                           : pct_q;
        end
    end

    // stage 6: times falloff
    logic [rflf_pkg::P2_W-1:0] px6_reg, py6_reg;
    rflf_pkg::ctl_t c6_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            c6_reg.vld <= 1'b0;
        end else if (en) begin
            c6_reg  <= c5_reg;
            px6_reg <= px5_reg * pct5_reg;
            py6_reg <= py5_reg * pct5_reg;
        end
    end

    // stage 7: round half away, sign, saturate, mask out of range or zero distance
    localparam int RND_W = rflf_pkg::P2_W + 1;
    localparam int MAG_W = RND_W - 2 * rflf_pkg::FRAC_W;

    logic [RND_W-1:0] rndx, rndy;
    logic             negx, negy, kill;
    logic             v7_reg;
    rflf_pkg::out_t   f7_reg;

    assign rndx = RND_W'(px6_reg) + (RND_W'(1) << (2 * rflf_pkg::FRAC_W - 1));
    assign rndy = RND_W'(py6_reg) + (RND_W'(1) << (2 * rflf_pkg::FRAC_W - 1));
    assign negx = c6_reg.sneg ^ c6_reg.xneg ^ c6_reg.attract;
    assign negy = c6_reg.sneg ^ c6_reg.yneg ^ c6_reg.attract;
    assign kill = !c6_reg.inr || c6_reg.zero;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v7_reg <= 1'b0;
        end else if (en) begin
            v7_reg          <= c6_reg.vld;
            f7_reg.in_range <= c6_reg.inr;
            f7_reg.force_x  <= kill ? '0
                             : sat_force(rndx[RND_W-1 -: MAG_W], negx);
            f7_reg.force_y  <= kill ? '0
                             : sat_force(rndy[RND_W-1 -: MAG_W], negy);
        end
    end

    // output register with skid word behind it
    logic           m_vld_reg;
    rflf_pkg::out_t m_data_reg, skid_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_vld_reg    <= 1'b0;
            skid_vld_reg <= 1'b0;
        end else if (m_ready || !m_vld_reg) begin
            if (skid_vld_reg) begin
                m_vld_reg    <= 1'b1;
                m_data_reg   <= skid_data_reg;
                skid_vld_reg <= 1'b0;
            end else begin
                m_vld_reg  <= v7_reg;
                m_data_reg <= f7_reg;
            end
        end else if (en && v7_reg) begin
            // output stalled: park the word leaving stage 7
            skid_vld_reg  <= 1'b1;
            skid_data_reg <= f7_reg;
        end
    end

    assign m_valid = m_vld_reg;
    assign m_data  = m_data_reg;

endmodule

// ===== rtl/rflf_checker.sv =====
// port-level checker for the radial force unit and its bind
`timescale 1ns / 1ps
`include "radial_force_linear_falloff_unit_assert.svh"

module rflf_checker (
    input logic           aclk,
    input logic           aresetn,
    input logic           s_valid,
    input logic           s_ready,
    input rflf_pkg::in_t  s_data,
    input logic           m_valid,
    input logic           m_ready,
    input rflf_pkg::out_t m_data
);

    // a held word keeps its value
    `RFLF_ASSERT(a_out_hold, aclk, aresetn, m_valid && !m_ready |=> m_valid && $stable(m_data))

    // out of range words carry no force
    `RFLF_ASSERT(a_no_force_out, aclk, aresetn, m_valid && !m_data.in_range |-> m_data.force_x == 0 && m_data.force_y == 0)

    // input backs off only behind a stalled output word
    `RFLF_ASSERT(a_ready_drop, aclk, aresetn, $fell(s_ready) |-> $past(m_valid && !m_ready))

    // nothing leaves right after reset
    `RFLF_ASSERT_ALWAYS(a_reset_quiet, aclk, $past(!aresetn) |-> !m_valid && s_ready)

endmodule

bind radial_force_linear_falloff_unit rflf_checker u_rflf_checker (.*);
